FILE: hdl/frwa_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate window average: shared package
// Widths, constants, register codes, queue item and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package frwa_pkg;

    // Window and fixed-point format
    localparam int WINDOW        = 8;
    localparam int FRAC_BITS     = 8;
    localparam int MS_PER_SECOND = 1000;

    // Field widths
    localparam int TS_W  = 32;
    localparam int FPS_W = 20;
    localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

    // Derived widths
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = TS_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int SCALE = MS_PER_SECOND * (2 ** FRAC_BITS);
    localparam int NUM_W = $clog2(SCALE * WINDOW + 1);
    localparam int REM_W = SUM_W + 1;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam int QX_W  = (NUM_W > FPS_W) ? NUM_W : FPS_W;

    // Stream data widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 72;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_FPS  = 1'b0,
        REG_WARMUP_MS = 1'b1
    } frwa_reg_t;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TS_W-1:0]  frame_time;
        logic             warm;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } frwa_item_t;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } frwa_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } frwa_back_state_t;

endpackage

`default_nettype wire

FILE: hdl/frame_rate_window_average_core.sv
// ----------------------------------------------------------------------------
// Frame rate window average core
// Sliding-window average of frame times, reported as frames per second in
// unsigned Q12.8, with a warm-up rate held until a configured timestamp.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata[31:0] timestamp_ms
//  m_*       out        tdata[31:0] frame_time_ms, [51:32] average_fps,
//                       [71:52] reported_fps; tuser[0] in_warmup
//  cfg_*     in         index 0 init_fps, index 1 warmup_ms
//
//  One request passes the front end (taken in F_IDLE, queued in F_UPDATE
//  once the queue has room) and the back end (taken from the queue in
//  B_IDLE, NUM_W = 21 divider steps in B_DIV, result register loaded in
//  B_DONE once it is free). The one-bit-per-cycle divider takes one
//  request at a time; a zero sum skips the divider.
//  A two-entry queue lets the front end take requests while the divider
//  works. Reset is synchronous and clears all control state; the frame
//  time ring is not cleared. The result register holds a stalled result
//  while the divider continues with the next request.
//
`default_nettype none

module frame_rate_window_average_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [frwa_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] timestamp_ms
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] frame_time_ms, [51:32] average_fps, [71:52] reported_fps
    output logic [frwa_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser,   // [0] in_warmup
    input  wire logic                           cfg_wr_en,
    input  wire logic [frwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frwa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import frwa_pkg::*;

    logic             push;
    frwa_item_t       push_item;
    logic             full;
    logic             pop;
    frwa_item_t       pop_item;
    logic             empty;
    logic [FPS_W-1:0] init_fps;

    frwa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .init_fps  (init_fps),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    frwa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    frwa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_item (pop_item),
        .empty    (empty),
        .pop      (pop),
        .init_fps (init_fps),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: hdl/frwa_front.sv
// ----------------------------------------------------------------------------
// Frame rate window average: front end
// Accepts timestamps, keeps the frame time ring, running sum and fill count,
// holds the configuration registers and queues one item per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module frwa_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [frwa_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [frwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frwa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [frwa_pkg::FPS_W-1:0]         init_fps,
    output logic                               push,
    output frwa_pkg::frwa_item_t               push_item,
    input  wire logic                          full
);
    import frwa_pkg::*;

    frwa_front_state_t state_reg, state_next;

    logic [FPS_W-1:0] init_fps_reg;
    logic [TS_W-1:0]  warmup_ms_reg;

    logic [TS_W-1:0]  ring_reg [WINDOW];
    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [TS_W-1:0]  last_time_reg;

    logic [TS_W-1:0]  ts;
    logic [TS_W-1:0]  ft_reg;
    logic             warm_reg;

    logic             ring_full;
    logic [SUM_W-1:0] sum_drop;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] ptr_next;
    logic             accept;

    assign ts         = s_tdata[TS_W-1:0];
    assign accept     = s_tvalid && s_tready;
    assign ring_full  = (count_reg == CNT_W'(WINDOW));
    assign sum_drop   = ring_full ? SUM_W'(ring_reg[ptr_reg]) : '0;
    assign sum_next   = sum_reg - sum_drop + SUM_W'(ft_reg);
    assign count_next = ring_full ? count_reg : count_reg + 1'b1;
    assign ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE: begin
                if (!full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            F_IDLE:   s_tready = 1'b1;
            F_UPDATE: push = !full;
            default: begin
                s_tready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    assign push_item.frame_time = ft_reg;
    assign push_item.warm       = warm_reg;
    assign push_item.count      = count_next;
    assign push_item.sum        = sum_next;
    assign init_fps             = init_fps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            init_fps_reg  <= FPS_W'(15360);
            warmup_ms_reg <= TS_W'(5000);
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            last_time_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_INIT_FPS:  init_fps_reg  <= cfg_wdata[FPS_W-1:0];
                    REG_WARMUP_MS: warmup_ms_reg <= cfg_wdata[TS_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                last_time_reg <= ts;
            end
            if (push) begin
                ptr_reg   <= ptr_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Frame time and warm-up flag are captured with the request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ft_reg   <= ts - last_time_reg;
            warm_reg <= (ts <= warmup_ms_reg);
        end
        if (push) begin
            ring_reg[ptr_reg] <= ft_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW))
        else $error("fill count above window size");
`endif

endmodule

`default_nettype wire

FILE: hdl/frwa_fifo.sv
// ----------------------------------------------------------------------------
// Frame rate window average: item queue
// Two-entry queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module frwa_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire frwa_pkg::frwa_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output frwa_pkg::frwa_item_t      pop_item,
    output logic                      empty
);
    import frwa_pkg::*;

    frwa_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/frwa_back.sv
// ----------------------------------------------------------------------------
// Frame rate window average: back end
// Radix-2 restoring divider for count*1000*2^FRAC_BITS / sum, saturation,
// warm-up selection and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frwa_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire frwa_pkg::frwa_item_t          pop_item,
    input  wire logic                          empty,
    output logic                               pop,
    input  wire logic [frwa_pkg::FPS_W-1:0]    init_fps,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [frwa_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import frwa_pkg::*;

    frwa_back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  div_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] step_reg;
    logic              zero_reg;
    logic              warm_reg;
    logic [TS_W-1:0]   ft_reg;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    logic [REM_W-1:0]  trial;
    logic              fits;
    logic              last_step;
    logic              out_free;
    logic              load_out;
    logic [QX_W-1:0]   quo_ext;
    logic [FPS_W-1:0]  avg;
    logic [FPS_W-1:0]  reported;

    assign trial     = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign fits      = (trial >= REM_W'(div_reg));
    assign last_step = (step_reg == DCNT_W'(NUM_W - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // A zero sum or a quotient beyond the field saturates.
    assign quo_ext  = QX_W'(quo_reg);
    assign avg      = (zero_reg || (quo_ext > QX_W'(FPS_MAX))) ? FPS_MAX
                                                               : quo_reg[FPS_W-1:0];
    assign reported = warm_reg ? init_fps : avg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    state_next = (pop_item.sum == '0) ? B_DONE : B_DIV;
                end
            end
            B_DIV: begin
                if (last_step) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE: pop = !empty;
            B_DIV:  ;
            B_DONE: load_out = out_free;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            div_reg  <= pop_item.sum;
            num_reg  <= NUM_W'(int'(pop_item.count) * SCALE);
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
            zero_reg <= (pop_item.sum == '0);
            warm_reg <= pop_item.warm;
            ft_reg   <= pop_item.frame_time;
        end else if (state_reg == B_DIV) begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= fits ? trial - REM_W'(div_reg) : trial;
            quo_reg  <= {quo_reg[NUM_W-2:0], fits};
            step_reg <= step_reg + 1'b1;
        end
        if (load_out) begin
            m_tdata_reg <= {reported, avg, ft_reg};
            m_tuser_reg <= warm_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (step_reg <= DCNT_W'(NUM_W - 1)))
        else $error("divider step count out of range");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == B_IDLE))
        else $error("queue read while divider busy");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
